### rtl/core/pt64_pkg.sv
package pt64_pkg;

    localparam int CAND_W    = 63;
    localparam int NUM_BASES = 12;
    localparam int BASE_W    = 6;
    localparam int BIDX_W    = 4;
    localparam int BIT_W     = 6;

    typedef logic [CAND_W-1:0] cand_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_STRIP,
        ST_BASE,
        ST_REDUCE,
        ST_POW_BIT,
        ST_POW_SQ,
        ST_MUL_WAIT,
        ST_EVAL,
        ST_SQ_LOOP,
        ST_SQ_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_STRIP,
        OP_BASE,
        OP_REDUCE,
        OP_MUL_RB,
        OP_MUL_BB,
        OP_MUL_VV,
        OP_STEP_E
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [BIDX_W-1:0] base_idx;
        logic             commit;
    } cmd_t;

    typedef struct packed {
        logic lt2;
        logic is_two;
        logic is_even;
        logic d_even;
        logic eq_base;
        logic b_ge_n;
        logic e_zero;
        logic e_lsb;
        logic v_one;
        logic v_nm1;
        logic s_zero;
        logic mul_busy;
    } stat_t;

    function automatic logic [BASE_W-1:0] base_val(input logic [BIDX_W-1:0] i);
        case (i)
            4'd0:    base_val = 6'd2;
            4'd1:    base_val = 6'd3;
            4'd2:    base_val = 6'd5;
            4'd3:    base_val = 6'd7;
            4'd4:    base_val = 6'd11;
            4'd5:    base_val = 6'd13;
            4'd6:    base_val = 6'd17;
            4'd7:    base_val = 6'd19;
            4'd8:    base_val = 6'd23;
            4'd9:    base_val = 6'd29;
            4'd10:   base_val = 6'd31;
            4'd11:   base_val = 6'd37;
            default: base_val = 6'd2;
        endcase
    endfunction

endpackage

### rtl/core/pt64_if.sv
interface pt64_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/core/pt64_ctrl.sv
module pt64_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  pt64_pkg::stat_t st,
    output pt64_pkg::cmd_t  cmd,
    output logic            busy,
    output logic            done,
    output logic            result,
    input  logic            take
);
    import pt64_pkg::*;

    state_t            state_reg, state_next;
    logic [BIDX_W-1:0] bidx_reg, bidx_next;
    logic              res_reg, res_next;
    logic              sq_reg, sq_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            bidx_reg  <= '0;
            res_reg   <= 1'b0;
            sq_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            bidx_reg  <= bidx_next;
            res_reg   <= res_next;
            sq_reg    <= sq_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bidx_next    = bidx_reg;
        res_next     = res_reg;
        sq_next      = sq_reg;
        cmd.op       = OP_NONE;
        cmd.base_idx = bidx_reg;
        cmd.commit   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                bidx_next = '0;
                if (st.lt2)
                begin
                    res_next = 1'b0; state_next = ST_DONE;
                end
                else if (st.is_two)
                begin
                    res_next = 1'b1; state_next = ST_DONE;
                end
                else if (st.is_even)
                begin
                    res_next = 1'b0; state_next = ST_DONE;
                end
                else
                    state_next = ST_STRIP;
            end
            ST_STRIP:
            begin
                // also scans bases for an exact match, one per cycle once d is odd
                if (st.eq_base)
                begin
                    res_next = 1'b1; state_next = ST_DONE;
                end
                else if (st.d_even)
                    cmd.op = OP_STRIP;
                else if (bidx_reg == BIDX_W'(NUM_BASES-1))
                begin
                    bidx_next = '0; state_next = ST_BASE;
                end
                else
                    bidx_next = bidx_reg + 1'b1;
            end
            ST_BASE:
            begin
                cmd.op     = OP_BASE;
                state_next = ST_REDUCE;
            end
            ST_REDUCE:
            begin
                // base can exceed a small n; subtract n until it is below
                if (st.b_ge_n)
                    cmd.op = OP_REDUCE;
                else
                    state_next = ST_POW_BIT;
            end
            ST_POW_BIT:
            begin
                if (st.e_zero)
                    state_next = ST_EVAL;
                else if (st.e_lsb)
                begin
                    cmd.op = OP_MUL_RB; sq_next = 1'b0; state_next = ST_MUL_WAIT;
                end
                else
                    state_next = ST_POW_SQ;
            end
            ST_POW_SQ:
            begin
                cmd.op = OP_MUL_BB; sq_next = 1'b1; state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (!st.mul_busy)
                begin
                    cmd.commit = 1'b1;
                    if (sq_reg)
                    begin
                        cmd.op = OP_STEP_E; state_next = ST_POW_BIT;
                    end
                    else
                        state_next = ST_POW_SQ;
                end
            end
            ST_EVAL:
                state_next = st.v_one ? ST_SQ_LOOP : ST_SQ_LOOP;
            ST_SQ_LOOP:
            begin
                // counter s is consumed by the datapath on each squaring
                if (st.v_one && !sq_reg)
                    sq_next = 1'b0;
                if (st.v_one || (!st.s_zero && st.v_nm1))
                begin
                    if (bidx_reg == BIDX_W'(NUM_BASES-1))
                    begin
                        res_next = 1'b1; state_next = ST_DONE;
                    end
                    else
                    begin
                        bidx_next = bidx_reg + 1'b1; state_next = ST_BASE;
                    end
                end
                else if (st.s_zero)
                begin
                    res_next = 1'b0; state_next = ST_DONE;
                end
                else
                begin
                    cmd.op = OP_MUL_VV; state_next = ST_SQ_WAIT;
                end
            end
            ST_SQ_WAIT:
            begin
                if (!st.mul_busy)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_SQ_LOOP;
                end
            end
            ST_DONE:
                if (take)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = (state_reg == ST_DONE);
    assign result = res_reg;

endmodule

### rtl/core/pt64_dp.sv
module pt64_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  pt64_pkg::cand_t cand,
    input  pt64_pkg::cmd_t  cmd,
    output pt64_pkg::stat_t st
);
    import pt64_pkg::*;

    cand_t            n_reg, d_reg, e_reg, b_reg, r_reg;
    logic [BIT_W-1:0] s_reg, sc_reg;
    logic             v1_reg;

    // shift-and-add modular multiplier, one bit a cycle, reuses r_reg as v
    cand_t            mx_reg, my_reg;
    logic [CAND_W:0]  acc_reg;
    logic [BIT_W-1:0] mbit_reg;
    logic             mbusy_reg;
    logic [1:0]       mdst_reg;

    localparam logic [1:0] DST_R = 2'd0, DST_B = 2'd1;

    logic [CAND_W:0] dbl, dbl_m, add1, add1_m;
    always_comb
    begin
        dbl   = {acc_reg[CAND_W-1:0], 1'b0};
        dbl_m = (dbl >= {1'b0, n_reg}) ? dbl - {1'b0, n_reg} : dbl;
        add1  = dbl_m + {1'b0, mx_reg};
        add1_m = (add1 >= {1'b0, n_reg}) ? add1 - {1'b0, n_reg} : add1;
    end

    logic [CAND_W:0] mres;
    assign mres = my_reg[mbit_reg] ? add1_m : dbl_m;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
        end
        else
        begin
            if (mbusy_reg)
            begin
                acc_reg <= mres;
                if (mbit_reg == '0)
                    mbusy_reg <= 1'b0;
                else
                    mbit_reg <= mbit_reg - 1'b1;
            end
            case (cmd.op)
                OP_MUL_RB:
                begin
                    mx_reg <= r_reg; my_reg <= b_reg; mdst_reg <= DST_R;
                    acc_reg <= '0; mbit_reg <= BIT_W'(CAND_W-1); mbusy_reg <= 1'b1;
                end
                OP_MUL_BB:
                begin
                    mx_reg <= b_reg; my_reg <= b_reg; mdst_reg <= DST_B;
                    acc_reg <= '0; mbit_reg <= BIT_W'(CAND_W-1); mbusy_reg <= 1'b1;
                end
                OP_MUL_VV:
                begin
                    mx_reg <= r_reg; my_reg <= r_reg; mdst_reg <= DST_R;
                    acc_reg <= '0; mbit_reg <= BIT_W'(CAND_W-1); mbusy_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                n_reg <= cand;
                d_reg <= cand - 1'b1;
                s_reg <= '0;
            end
            OP_STRIP:
            begin
                d_reg <= d_reg >> 1;
                s_reg <= s_reg + 1'b1;
            end
            OP_BASE:
            begin
                b_reg  <= CAND_W'(base_val(cmd.base_idx));
                r_reg  <= CAND_W'(1);
                e_reg  <= d_reg;
                sc_reg <= s_reg;
                v1_reg <= 1'b0;
            end
            OP_REDUCE:
                b_reg <= b_reg - n_reg;
            OP_MUL_VV:
            begin
                sc_reg <= sc_reg - 1'b1;
                v1_reg <= 1'b1;
            end
            default: ;
        endcase
        if (cmd.commit)
        begin
            if (mdst_reg == DST_B)
                b_reg <= acc_reg[CAND_W-1:0];
            else
                r_reg <= acc_reg[CAND_W-1:0];
        end
        if (cmd.op == OP_STEP_E)
            e_reg <= e_reg >> 1;
    end

    // bases are below 38, so a few subtractions bring one below n
    always_comb
    begin
        st.lt2      = (n_reg < CAND_W'(2));
        st.is_two   = (n_reg == CAND_W'(2));
        st.is_even  = ~n_reg[0];
        st.d_even   = ~d_reg[0];
        st.eq_base  = (n_reg == CAND_W'(base_val(cmd.base_idx)));
        st.b_ge_n   = (b_reg >= n_reg);
        st.e_zero   = (e_reg == '0);
        st.e_lsb    = e_reg[0];
        // plain 1 counts only before any squaring of v
        st.v_one    = (r_reg == CAND_W'(1)) && !v1_reg;
        st.v_nm1    = (r_reg == n_reg - 1'b1);
        st.s_zero   = (sc_reg == '0);
        st.mul_busy = mbusy_reg;
    end

endmodule

### rtl/core/primality_test_64_top.sv
// Each modular multiply is issued, steps through its operand bit by bit, then commits;
// a word is tested against up to 12 bases, with a modular exponentiation for each.
// Throughput: one word at a time; the bit-serial multiplier sets the rate.
// Result is held in the controller until taken; the next word enters after.
// rst_n is asynchronous, active low, and clears the controller and the multiplier busy flag.
module primality_test_64_top (
    input logic clk,
    input logic rst_n,
    pt64_if.sink   in_ch,
    pt64_if.source out_ch
);
    import pt64_pkg::*;

    cmd_t  cmd;
    stat_t st;
    logic  busy, done, result, start, take;

    assign in_ch.ready  = !busy;
    assign start        = in_ch.valid && !busy;
    assign out_ch.valid = done;
    assign out_ch.data  = result;
    assign take         = out_ch.ready;

    pt64_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .st(st), .cmd(cmd),
        .busy(busy), .done(done), .result(result), .take(take)
    );

    pt64_dp u_dp (
        .clk(clk), .rst_n(rst_n), .cand(in_ch.data[CAND_W-1:0]), .cmd(cmd), .st(st)
    );

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !in_ch.ready) else $error("input taken while busy");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done outside busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !out_ch.ready) |=> (done && $stable(result)))
        else $error("result dropped");

endmodule
